// ===== rtl/skf_pkg.sv =====
// shared types and constants for the scalar kalman temperature filter
// no dependencies; used by skf_gain_mac and scalar_kalman_temperature_filter
`default_nettype none

package skf_pkg;

  // converter resolution and the byte-padded input bus width
  localparam int ADC_BITS  = 12;
  localparam int S_TDATA_W = ((ADC_BITS + 7) / 8) * 8;

  // field widths
  localparam int TEMP_W   = 17;
  localparam int COV_W    = 24;
  localparam int GAIN_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int DEN_W    = COV_W + 1;
  localparam int REM_W    = COV_W + 2;
  localparam int DIFF_W   = TEMP_W + 1;
  localparam int ACCX_W   = GAIN_W + DIFF_W;
  localparam int ACCP_W   = FRAC_W + COV_W;
  localparam int XSUM_W   = ACCX_W - FRAC_W;
  localparam int PROD_W   = ADC_BITS + TEMP_W;
  localparam int CNT_W    = $clog2(GAIN_W);
  localparam int M_TDATA_W = ((2 * TEMP_W + 7) / 8) * 8;

  // 3.3 / 2^ADC_BITS * 100 * 256, applied as multiply then shift
  localparam logic [PROD_W-1:0] TEMP_SCALE = PROD_W'(84480);
  localparam logic [TEMP_W-1:0] TEMP_MAX   = {TEMP_W{1'b1}};
  localparam logic [TEMP_W-1:0] Z_MAX      =
    TEMP_W'(((2 ** ADC_BITS - 1) * 84480) / (2 ** ADC_BITS));
  localparam logic [COV_W-1:0]  COV_MAX    = {COV_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);

  // register reset values
  localparam logic [COV_W-1:0] Q_RESET = COV_W'(1311);
  localparam logic [COV_W-1:0] R_RESET = COV_W'(6554);
  localparam logic [COV_W-1:0] P_RESET = COV_W'(65536);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FINISH
  } state_t;

  // status of the serial gain unit
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } mac_stat_t;

endpackage

`default_nettype wire

// ===== rtl/skf_gain_mac.sv =====
// serial gain divider fused with the two update multiply-accumulates
// depends on skf_pkg
`default_nettype none

module skf_gain_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [skf_pkg::COV_W-1:0]           p_pred,
  input  logic [skf_pkg::DEN_W-1:0]           den,
  input  logic signed [skf_pkg::DIFF_W-1:0]   diff,
  output skf_pkg::mac_stat_t                  stat,
  output logic signed [skf_pkg::ACCX_W-1:0]   acc_x,
  output logic [skf_pkg::ACCP_W-1:0]          acc_p
);

  logic                                busy;
  logic                                done;
  logic [skf_pkg::CNT_W-1:0]           cnt;
  logic [skf_pkg::REM_W-1:0]           rem;
  logic [skf_pkg::DEN_W-1:0]           den_r;
  logic                                den_nz;
  logic [skf_pkg::COV_W-1:0]           p_r;
  logic signed [skf_pkg::DIFF_W-1:0]   diff_r;
  logic [skf_pkg::GAIN_W-1:0]          gain;

  logic                                q_bit;
  logic [skf_pkg::REM_W-1:0]           rem_red;
  logic [skf_pkg::REM_W-1:0]           rem_next;
  logic signed [skf_pkg::ACCX_W-1:0]   addend_x;
  logic [skf_pkg::ACCP_W-1:0]          addend_p;

  // restoring division, quotient msb first; each quotient bit also
  // steers one shift-add step of gain*diff and gain*p
  always_comb begin
    q_bit    = den_nz && (rem >= {1'b0, den_r});
    rem_red  = q_bit ? (rem - {1'b0, den_r}) : rem;
    rem_next = {rem_red[skf_pkg::REM_W-2:0], 1'b0};
    addend_x = q_bit ? skf_pkg::ACCX_W'(diff_r) : '0;
    addend_p = q_bit ? skf_pkg::ACCP_W'(p_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt    <= skf_pkg::CNT_W'(skf_pkg::GAIN_W - 1);
      rem    <= skf_pkg::REM_W'(p_pred);
      den_r  <= den;
      den_nz <= (den != '0);
      p_r    <= p_pred;
      diff_r <= diff;
      gain   <= '0;
      acc_x  <= '0;
      acc_p  <= '0;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      rem   <= rem_next;
      gain  <= {gain[skf_pkg::GAIN_W-2:0], q_bit};
      acc_x <= (acc_x <<< 1) + addend_x;
      acc_p <= (acc_p << 1) + addend_p;
    end
  end

  assign stat.done = done;
  assign stat.gain = gain;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_temperature_filter.sv =====
// top level of the scalar kalman temperature filter
// depends on skf_pkg and skf_gain_mac
`default_nettype none

// Takes one raw converter reading per transaction, scales it to 1/256
// degree Celsius and runs a one-dimensional Kalman filter on it (predict
// P+Q saturating, gain K=P/(P+R) in Q1.16, estimate X+K*(z-X), covariance
// (1-K)*P). Each input transaction yields exactly one output transaction
// with the measured and the filtered temperature. From acceptance to the
// result: scaling and predict are registered at the accepting edge, then
// the PREP state loads the divisor and difference into the serial unit,
// the bit-serial gain divider runs (which also drives the two shift-add
// multiplies), the RUN state sees its done flag and the FINISH state hands
// the result over while the state is updated. With a free output register
// the next item is accepted in the following cycle. The next item is
// accepted as soon as the core is idle, even while the previous result
// still waits in the output register. Configuration writes (Q at index 0,
// R at index 1) belong to idle periods; R must not be zero.

module scalar_kalman_temperature_filter (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skf_pkg::COV_W-1:0]         cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [skf_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // raw_sample
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [skf_pkg::M_TDATA_W-1:0]     m_axis_tdata    // measured_temp, filtered_temp
);

  skf_pkg::state_t                      state;
  skf_pkg::state_t                      state_next;

  // configuration and filter state
  logic [skf_pkg::COV_W-1:0]            process_noise;
  logic [skf_pkg::COV_W-1:0]            measurement_noise;
  logic [skf_pkg::TEMP_W-1:0]           estimate;
  logic [skf_pkg::COV_W-1:0]            error_covariance;

  // per-item working registers
  logic [skf_pkg::TEMP_W-1:0]           meas;
  logic [skf_pkg::COV_W-1:0]            p_pred;

  // output register
  logic                                 out_valid;
  logic [skf_pkg::TEMP_W-1:0]           out_meas;
  logic [skf_pkg::TEMP_W-1:0]           out_filt;

  logic                                 s_accept;
  logic                                 mac_start;
  logic                                 fin;
  logic [skf_pkg::PROD_W-1:0]           z_prod;
  logic [skf_pkg::COV_W:0]              p_sum;
  logic [skf_pkg::COV_W-1:0]            p_sat;
  logic [skf_pkg::DEN_W-1:0]            den;
  logic signed [skf_pkg::DIFF_W-1:0]    diff;
  logic signed [skf_pkg::XSUM_W-1:0]    x_sum;
  logic [skf_pkg::TEMP_W-1:0]           x_new;
  logic [skf_pkg::ACCP_W-1:0]           p_rest;
  logic [skf_pkg::COV_W-1:0]            cov_new;

  skf_pkg::mac_stat_t                   mac_stat;
  logic signed [skf_pkg::ACCX_W-1:0]    acc_x;
  logic [skf_pkg::ACCP_W-1:0]           acc_p;

  assign s_axis_tready = (state == skf_pkg::ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // measurement scaling: z = floor(raw * 84480 / 2^ADC_BITS)
  assign z_prod = skf_pkg::PROD_W'(s_axis_tdata[skf_pkg::ADC_BITS-1:0])
                  * skf_pkg::TEMP_SCALE;

  // predict with saturation at the covariance maximum
  assign p_sum = {1'b0, error_covariance} + {1'b0, process_noise};
  assign p_sat = p_sum[skf_pkg::COV_W] ? skf_pkg::COV_MAX : p_sum[skf_pkg::COV_W-1:0];

  // divisor and innovation for the serial unit
  assign den  = {1'b0, p_pred} + {1'b0, measurement_noise};
  assign diff = $signed({1'b0, meas}) - $signed({1'b0, estimate});

  // estimate update: floor shift of k*diff, clamped to the temperature range
  assign x_sum = $signed({2'b00, estimate})
                 + $signed(acc_x[skf_pkg::ACCX_W-1:skf_pkg::FRAC_W]);
  always_comb begin
    if (x_sum < 0) begin
      x_new = '0;
    end else if (x_sum[skf_pkg::XSUM_W-2:skf_pkg::TEMP_W] != '0) begin
      x_new = skf_pkg::TEMP_MAX;
    end else begin
      x_new = x_sum[skf_pkg::TEMP_W-1:0];
    end
  end

  // (1-k)*p = p*2^16 - k*p
  assign p_rest  = {p_pred, {skf_pkg::FRAC_W{1'b0}}} - acc_p;
  assign cov_new = p_rest[skf_pkg::ACCP_W-1:skf_pkg::FRAC_W];

  skf_gain_mac u_gain_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .p_pred (p_pred),
    .den    (den),
    .diff   (diff),
    .stat   (mac_stat),
    .acc_x  (acc_x),
    .acc_p  (acc_p)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_start  = 1'b0;
    fin        = 1'b0;
    case (state)
      skf_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = skf_pkg::ST_PREP;
        end
      end
      skf_pkg::ST_PREP: begin
        mac_start  = 1'b1;
        state_next = skf_pkg::ST_RUN;
      end
      skf_pkg::ST_RUN: begin
        if (mac_stat.done) begin
          state_next = skf_pkg::ST_FINISH;
        end
      end
      skf_pkg::ST_FINISH: begin
        // wait here only while an older result still occupies the output
        if (!out_valid || m_axis_tready) begin
          fin        = 1'b1;
          state_next = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = skf_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= skf_pkg::Q_RESET;
      measurement_noise <= skf_pkg::R_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:     process_noise     <= cfg_data;
        skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // filter state, committed when the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate         <= '0;
      error_covariance <= skf_pkg::P_RESET;
    end else if (fin) begin
      estimate         <= x_new;
      error_covariance <= cov_new;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      meas   <= z_prod[skf_pkg::ADC_BITS +: skf_pkg::TEMP_W];
      p_pred <= p_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_meas <= meas;
      out_filt <= x_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(skf_pkg::M_TDATA_W - 2 * skf_pkg::TEMP_W){1'b0}},
                          out_filt, out_meas};

  // the measured temperature never leaves the scaled converter range
  a_meas_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_meas <= skf_pkg::Z_MAX)
    else $error("measured temperature out of range");

  // the gain from the divider never exceeds one
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    mac_stat.done |-> mac_stat.gain <= skf_pkg::GAIN_ONE)
    else $error("kalman gain above one");

  // the updated covariance never exceeds the predicted one
  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    fin |=> error_covariance <= $past(p_pred))
    else $error("covariance grew in update");

  // the new estimate lies between the old estimate and the measurement
  a_est_between: assert property (@(posedge clk) disable iff (rst)
    fin |=> ((estimate >= $past(estimate) && estimate <= $past(meas)) ||
             (estimate <= $past(estimate) && estimate >= $past(meas))))
    else $error("estimate left the innovation interval");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking bench for scalar_kalman_temperature_filter
// depends on skf_pkg and the filter rtl; needs no files or arguments
`timescale 1ns / 100ps

module tb_top;
  import skf_pkg::*;

  // one output transaction: measured_temp and filtered_temp
  typedef struct packed {
    logic [TEMP_W-1:0] measured;
    logic [TEMP_W-1:0] filtered;
  } temp_pair_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PROCESS_NOISE;
  logic [COV_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // raw_sample, zero padded
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // measured_temp, filtered_temp

  scalar_kalman_temperature_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // filter state mirrored on the bench side
  logic [COV_W-1:0]  noise_q = Q_RESET;
  logic [COV_W-1:0]  noise_r = R_RESET;
  logic [TEMP_W-1:0] est_temp = '0;
  logic [COV_W-1:0]  est_cov = P_RESET;

  logic [ADC_BITS-1:0] pending_samples[$];
  temp_pair_t          expected_temps[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int walk_level = 1200;

  // one predict/update step of the scalar kalman filter on a raw reading
  function automatic temp_pair_t filter_update(input logic [ADC_BITS-1:0] raw);
    longint z, cov, den, gain, diff, x;
    temp_pair_t res;
    z = (longint'(raw) * longint'(TEMP_SCALE)) >> ADC_BITS;
    // predict with saturation at the covariance width
    cov = longint'(est_cov) + longint'(noise_q);
    if (cov > longint'(COV_MAX)) cov = longint'(COV_MAX);
    den = cov + longint'(noise_r);
    gain = 0;
    if (den != 0) gain = (cov * longint'(GAIN_ONE)) / den;
    if (gain > longint'(GAIN_ONE)) gain = longint'(GAIN_ONE);
    // arithmetic shift floors toward minus infinity on a negative innovation
    diff = z - longint'(est_temp);
    x = longint'(est_temp) + ((gain * diff) >>> FRAC_W);
    if (x < 0) x = 0;
    if (x > longint'(TEMP_MAX)) x = longint'(TEMP_MAX);
    est_temp = TEMP_W'(x);
    cov = ((longint'(GAIN_ONE) - gain) * cov) >> FRAC_W;
    est_cov = COV_W'(cov);
    res.measured = TEMP_W'(z);
    res.filtered = est_temp;
    return res;
  endfunction

  // mostly a slowly drifting sensor with small noise, plus wild readings
  function automatic logic [ADC_BITS-1:0] next_reading();
    int pick, v;
    pick = $urandom_range(99);
    if (pick < 60) begin
      walk_level = walk_level + $urandom_range(6) - 3;
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 4095) walk_level = 4095;
      v = walk_level + $urandom_range(16) - 8;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return ADC_BITS'(v);
    end else if (pick < 85) begin
      return ADC_BITS'($urandom_range(4095));
    end else if (pick < 95) begin
      return ($urandom_range(1) != 0) ? {ADC_BITS{1'b1}} : '0;
    end
    // step change of the underlying temperature
    walk_level = $urandom_range(4095);
    return ADC_BITS'(walk_level);
  endfunction

  // driver: holds a transaction until accepted, predicts at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_temps.push_back(filter_update(s_axis_tdata[ADC_BITS-1:0]));
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_TDATA_W'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_temps.size() == 0) begin
          $display("%0t: unexpected result measured=%0d filtered=%0d", $realtime,
                   m_axis_tdata[TEMP_W-1:0], m_axis_tdata[2*TEMP_W-1:TEMP_W]);
          mismatches++;
        end else begin
          if (m_axis_tdata[TEMP_W-1:0] !== expected_temps[0].measured) begin
            $display("%0t: measured_temp expected %0d actual %0d", $realtime,
                     expected_temps[0].measured, m_axis_tdata[TEMP_W-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[2*TEMP_W-1:TEMP_W] !== expected_temps[0].filtered) begin
            $display("%0t: filtered_temp expected %0d actual %0d", $realtime,
                     expected_temps[0].filtered, m_axis_tdata[2*TEMP_W-1:TEMP_W]);
            mismatches++;
          end
          void'(expected_temps.pop_front());
          results_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // block is idle once nothing is queued, pending or in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid ||
           expected_temps.size() != 0 || !s_axis_tready);
  endtask

  // both noise registers in back-to-back cycles
  task automatic set_noise(input logic [COV_W-1:0] q, input logic [COV_W-1:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_data <= q;
    @(posedge clk);
    cfg_index <= REG_MEASUREMENT_NOISE;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    noise_q = q;
    noise_r = r;
    settings_used++;
  endtask

  // stimulus: nine phases of noise settings, the first also with directed extremes
  initial begin
    logic [ADC_BITS-1:0] corner_readings[$];
    logic [COV_W-1:0] q_set, r_set;
    corner_readings = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4094,
                        12'd2048, 12'd2047, 12'hAAA, 12'h555, 12'h800, 12'h7FF,
                        12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0,
                        12'd1234, 12'd1240, 12'd1236};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 9; phase++) begin
      // receiver then sender idles heavily, then neither does
      if (phase < 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 65;
      end else if (phase < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          foreach (corner_readings[i]) pending_samples.push_back(corner_readings[i]);
        end
        1: set_noise('0, COV_W'(1));
        2: set_noise(COV_MAX, COV_MAX);
        3: set_noise(COV_MAX, COV_W'(1));    // covariance saturates every step
        4: set_noise('0, COV_MAX);
        5: set_noise(Q_RESET, R_RESET);
        6: begin
          q_set = COV_W'($urandom_range(4095));
          r_set = COV_W'($urandom_range(65535, 1));
          set_noise(q_set, r_set);
        end
        default: begin
          q_set = COV_W'($urandom_range(24'hFFFFFF));
          r_set = COV_W'($urandom_range(24'hFFFFFF, 1));
          set_noise(q_set, r_set);
        end
      endcase
      @(negedge clk);
      repeat (176) pending_samples.push_back(next_reading());
      wait_drained();
    end

    // let any stray result show up before deciding
    repeat (40) @(posedge clk);
    $display("filtered %0d readings under %0d noise settings, %0d results checked",
             samples_sent, settings_used, results_checked);
    $display("directed extremes, saturating covariance and three idling patterns");
    if (mismatches == 0 && expected_temps.size() == 0) begin
      $display("[scalar_kalman_temperature_filter] OK");
    end else begin
      $display("[scalar_kalman_temperature_filter] ERROR");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_temps.size());
    $display("[scalar_kalman_temperature_filter] ERROR");
    $finish;
  end

endmodule
